/* hdl/abt_pkg.sv */
// Package for the expiring address ban table: widths, codes and shared types.
// Used by abt_cmp and expiring_address_ban_table; depends on nothing.
package abt_pkg;

   localparam int ENTRIES_DEF   = 64;
   localparam int TIME_BITS_DEF = 48;

   localparam int KEY_W     = 64;
   localparam int ACT_W     = 2;
   localparam int TIME_IN_W = 48;
   localparam int DUR_W     = 32;
   localparam int STAT_W    = 3;
   localparam int CNT_W     = 7;
   localparam int MODE_W    = 2;

   localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

   // Request payload: addr_high, addr_low, current_time, new_action, duration.
   localparam int REQ_DATA_W = 216;
   // Result payload: found, action_out, status, removed_count.
   localparam int RSP_DATA_W = 16;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOOKUP = 2'd0,
      MODE_SET    = 2'd1,
      MODE_SWEEP  = 2'd2,
      MODE_NOP    = 2'd3
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_NONE     = 3'd0,
      STAT_INSERTED = 3'd1,
      STAT_UPDATED  = 3'd2,
      STAT_REMOVED  = 3'd3,
      STAT_FULL     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TAIL,
      ST_COMMIT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic key_eq;
      logic expired;
   } cmp_res_type;

   typedef struct packed {
      logic ready;
      logic scan;
      logic commit;
      logic resp_load;
   } ctrl_type;

endpackage

/* hdl/abt_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; holds the table rows of the ban table.
module abt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* hdl/abt_cmp.sv */
// Shared compare unit: key equality and expiry test for one table row.
// Depends on abt_pkg.
module abt_cmp #(
   parameter int TIME_BITS = abt_pkg::TIME_BITS_DEF
) (
   input  logic [abt_pkg::KEY_W-1:0] row_key_hi,
   input  logic [abt_pkg::KEY_W-1:0] row_key_lo,
   input  logic [TIME_BITS-1:0]      row_expiry,
   input  logic [abt_pkg::KEY_W-1:0] req_key_hi,
   input  logic [abt_pkg::KEY_W-1:0] req_key_lo,
   input  logic [TIME_BITS-1:0]      now,
   output abt_pkg::cmp_res_type      res
);

   always_comb begin
      res.key_eq  = (row_key_hi == req_key_hi) && (row_key_lo == req_key_lo);
      // An entry is stale once its expiry has been reached.
      res.expired = (row_expiry <= now);
   end

endmodule

/* hdl/expiring_address_ban_table.sv */
// A request walks the table in ST_SCAN, then passes ST_TAIL and ST_COMMIT to ST_RESP, which
// registers the result; an unused mode goes straight to ST_RESP. The single compare unit walks
// the table one row per cycle via the RAM read port; a new request waits until ST_RESP is left.
// A new request is accepted while the previous result still waits on the output.
// Reset (synchronous) empties the table at once by clearing the per-entry valid bits;
// there is no clearing pass.
module expiring_address_ban_table #(
   parameter int ENTRIES   = abt_pkg::ENTRIES_DEF,
   parameter int TIME_BITS = abt_pkg::TIME_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // mode
   input  logic [abt_pkg::MODE_W-1:0]     req_tuser,
   // addr_high, addr_low, current_time, new_action, duration, zero fill
   input  logic [abt_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // found, action_out, status, removed_count, zero fill
   output logic [abt_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int WORD_W = 2 * abt_pkg::KEY_W + abt_pkg::ACT_W + TIME_BITS;
   localparam int KLO_LSB = 0;
   localparam int KHI_LSB = abt_pkg::KEY_W;
   localparam int ACT_LSB = 2 * abt_pkg::KEY_W;
   localparam int EXP_LSB = ACT_LSB + abt_pkg::ACT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
   localparam logic [64:0] TIME_MAX_W = (65'd1 << TIME_BITS) - 65'd1;

   // Request field unpacking.
   logic [abt_pkg::KEY_W-1:0]     f_addr_high;
   logic [abt_pkg::KEY_W-1:0]     f_addr_low;
   logic [abt_pkg::TIME_IN_W-1:0] f_current_time;
   logic [abt_pkg::ACT_W-1:0]     f_new_action;
   logic [abt_pkg::DUR_W-1:0]     f_duration;
   logic [63:0]                   cur_ext;
   logic [TIME_BITS-1:0]          f_now;
   logic [64:0]                   exp_sum;
   logic [TIME_BITS-1:0]          f_exp;
   logic                          req_acc;

   assign f_addr_high    = req_tdata[63:0];
   assign f_addr_low     = req_tdata[127:64];
   assign f_current_time = req_tdata[175:128];
   assign f_new_action   = req_tdata[177:176];
   assign f_duration     = req_tdata[209:178];
   assign cur_ext        = 64'(f_current_time);
   assign f_now          = cur_ext[TIME_BITS-1:0];
   assign exp_sum        = 65'(f_now) + 65'(f_duration);
   assign f_exp          = (exp_sum > TIME_MAX_W) ? '1 : exp_sum[TIME_BITS-1:0];

   // Control state.
   abt_pkg::state_type state_ff, state_in;
   abt_pkg::ctrl_type  ctrl;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic               chk_vld_ff, chk_vld_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Request and working registers.
   abt_pkg::mode_type             mode_ff, mode_in;
   logic [abt_pkg::KEY_W-1:0]     key_hi_ff, key_hi_in;
   logic [abt_pkg::KEY_W-1:0]     key_lo_ff, key_lo_in;
   logic [TIME_BITS-1:0]          now_ff, now_in;
   logic [TIME_BITS-1:0]          exp_ff, exp_in;
   logic [abt_pkg::ACT_W-1:0]     act_ff, act_in;
   logic                          dur_zero_ff, dur_zero_in;
   logic [IDX_W-1:0]              raddr_ff, raddr_in;
   logic [IDX_W-1:0]              chk_idx_ff, chk_idx_in;
   logic                          match_ff, match_in;
   logic [IDX_W-1:0]              match_idx_ff, match_idx_in;
   logic                          free_ff, free_in;
   logic [IDX_W-1:0]              free_idx_ff, free_idx_in;
   logic                          found_ff, found_in;
   logic [abt_pkg::ACT_W-1:0]     action_ff, action_in;
   abt_pkg::status_type           status_ff, status_in;
   logic [abt_pkg::CNT_W-1:0]     removed_ff, removed_in;
   logic [abt_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Table RAM and compare unit.
   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   logic [WORD_W-1:0]    ram_wr_data;
   logic [WORD_W-1:0]    ram_rd_data;
   abt_pkg::cmp_res_type cmp;
   logic                 row_valid;
   logic                 row_hit;

   abt_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ctrl.scan),
      .rd_addr (raddr_ff),
      .rd_data (ram_rd_data)
   );

   abt_cmp #(
      .TIME_BITS (TIME_BITS)
   ) u_cmp (
      .row_key_hi (ram_rd_data[KHI_LSB +: abt_pkg::KEY_W]),
      .row_key_lo (ram_rd_data[KLO_LSB +: abt_pkg::KEY_W]),
      .row_expiry (ram_rd_data[EXP_LSB +: TIME_BITS]),
      .req_key_hi (key_hi_ff),
      .req_key_lo (key_lo_ff),
      .now        (now_ff),
      .res        (cmp)
   );

   assign req_acc   = req_tvalid && ctrl.ready;
   assign row_valid = chk_vld_ff && valid_ff[chk_idx_ff];
   assign row_hit   = row_valid && cmp.key_eq;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         abt_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (abt_pkg::mode_type'(req_tuser) == abt_pkg::MODE_NOP) begin
                  state_in = abt_pkg::ST_RESP;
               end else begin
                  state_in = abt_pkg::ST_SCAN;
               end
            end
         end
         abt_pkg::ST_SCAN: begin
            if (raddr_ff == LAST_IDX) begin
               state_in = abt_pkg::ST_TAIL;
            end
         end
         abt_pkg::ST_TAIL:   state_in = abt_pkg::ST_COMMIT;
         abt_pkg::ST_COMMIT: state_in = abt_pkg::ST_RESP;
         abt_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = abt_pkg::ST_IDLE;
            end
         end
         default: state_in = abt_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      ctrl = '0;
      case (state_ff)
         abt_pkg::ST_IDLE:   ctrl.ready = 1'b1;
         abt_pkg::ST_SCAN:   ctrl.scan = 1'b1;
         abt_pkg::ST_TAIL:   ctrl = '0;
         abt_pkg::ST_COMMIT: ctrl.commit = 1'b1;
         abt_pkg::ST_RESP:   ctrl.resp_load = !rsp_valid_ff || rsp_tready;
         default:            ctrl = '0;
      endcase
   end

   // Datapath.
   always_comb begin
      mode_in      = mode_ff;
      key_hi_in    = key_hi_ff;
      key_lo_in    = key_lo_ff;
      now_in       = now_ff;
      exp_in       = exp_ff;
      act_in       = act_ff;
      dur_zero_in  = dur_zero_ff;
      raddr_in     = raddr_ff;
      chk_idx_in   = chk_idx_ff;
      chk_vld_in   = 1'b0;
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      found_in     = found_ff;
      action_in    = action_ff;
      status_in    = status_ff;
      removed_in   = removed_ff;
      valid_in     = valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = match_idx_ff;
      ram_wr_data  = {exp_ff, act_ff, key_hi_ff, key_lo_ff};

      if (req_acc) begin
         mode_in     = abt_pkg::mode_type'(req_tuser);
         key_hi_in   = f_addr_high;
         key_lo_in   = f_addr_low;
         now_in      = f_now;
         exp_in      = f_exp;
         act_in      = f_new_action;
         dur_zero_in = (f_duration == '0);
         raddr_in    = '0;
         match_in    = 1'b0;
         free_in     = 1'b0;
         found_in    = 1'b0;
         action_in   = '0;
         status_in   = abt_pkg::STAT_NONE;
         removed_in  = '0;
      end

      if (ctrl.scan) begin
         raddr_in   = IDX_W'(raddr_ff + 1'b1);
         chk_vld_in = 1'b1;
         chk_idx_in = raddr_ff;
      end

      // One table row arrives from the RAM per cycle and is judged here.
      if (row_hit && !match_ff) begin
         match_in     = 1'b1;
         match_idx_in = chk_idx_ff;
      end
      if (chk_vld_ff && !valid_ff[chk_idx_ff] && !free_ff) begin
         free_in     = 1'b1;
         free_idx_in = chk_idx_ff;
      end
      case (mode_ff)
         abt_pkg::MODE_LOOKUP: begin
            if (row_hit) begin
               if (cmp.expired) begin
                  valid_in[chk_idx_ff] = 1'b0;
                  removed_in           = abt_pkg::CNT_W'(1);
               end else begin
                  found_in  = 1'b1;
                  action_in = ram_rd_data[ACT_LSB +: abt_pkg::ACT_W];
               end
            end
         end
         abt_pkg::MODE_SWEEP: begin
            if (row_valid && cmp.expired) begin
               valid_in[chk_idx_ff] = 1'b0;
               if (removed_ff != abt_pkg::CNT_MAX) begin
                  removed_in = abt_pkg::CNT_W'(removed_ff + 1'b1);
               end
            end
         end
         abt_pkg::MODE_SET: ;
         default: ;
      endcase

      if (ctrl.commit && mode_ff == abt_pkg::MODE_SET) begin
         if (dur_zero_ff) begin
            if (match_ff) begin
               valid_in[match_idx_ff] = 1'b0;
               status_in              = abt_pkg::STAT_REMOVED;
            end
         end else if (match_ff) begin
            ram_wr_en = 1'b1;
            status_in = abt_pkg::STAT_UPDATED;
         end else if (free_ff) begin
            ram_wr_en             = 1'b1;
            ram_wr_addr           = free_idx_ff;
            valid_in[free_idx_ff] = 1'b1;
            status_in             = abt_pkg::STAT_INSERTED;
         end else begin
            status_in = abt_pkg::STAT_FULL;
         end
      end

      if (ctrl.resp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = abt_pkg::RSP_DATA_W'({removed_ff, status_ff, action_ff, found_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= abt_pkg::ST_IDLE;
         valid_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      key_hi_ff    <= key_hi_in;
      key_lo_ff    <= key_lo_in;
      now_ff       <= now_in;
      exp_ff       <= exp_in;
      act_ff       <= act_in;
      dur_zero_ff  <= dur_zero_in;
      raddr_ff     <= raddr_in;
      chk_idx_ff   <= chk_idx_in;
      match_ff     <= match_in;
      match_idx_ff <= match_idx_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      found_ff     <= found_in;
      action_ff    <= action_in;
      status_ff    <= status_in;
      removed_ff   <= removed_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_tready = ctrl.ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Keys are unique among live entries, so a second hit in one walk is a fault.
   a_unique_key: assert property (@(posedge clock) disable iff (reset)
      !(row_hit && match_ff))
      else $error("second live entry with the same key");

   // A table write always leaves the written entry live.
   a_write_valid: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> valid_ff[$past(ram_wr_addr)])
      else $error("table row written without its valid bit");

   // A lookup hit never reports an expiry removal or a status.
   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[0] |-> rsp_data_ff[12:3] == '0)
      else $error("lookup hit with status or removal");

   // No row is judged while the sequencer is idle.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == abt_pkg::ST_IDLE |-> !chk_vld_ff)
      else $error("row compare outside a table walk");

endmodule
